### sv/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg: shared types and constants of the planar-to-chunky blitter
// Register indexes, field widths and the position and geometry records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p2c_pkg;

  // frame geometry used for the reset values of the rectangle size
  localparam int unsigned SCREEN_WIDTH  = 640;
  localparam int unsigned SCREEN_HEIGHT = 480;

  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned PITCH_W = 12;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned PIX_W   = 4;
  localparam int unsigned PLANES  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = PITCH_W;

  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_BLOCK_WIDTH  = 3'd2,
    CFG_BLOCK_HEIGHT = 3'd3,
    CFG_LINE_PITCH   = 3'd4
  } cfg_idx_e;

  // current position inside the rectangle
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  // placement of the rectangle in the frame store
  typedef struct packed {
    logic [COL_W-1:0]   origin_x;
    logic [ROW_W-1:0]   origin_y;
    logic [PITCH_W-1:0] pitch;
  } geom_t;

endpackage

`default_nettype wire

### sv/p2c_pixel_calc.sv
// ----------------------------------------------------------------------------
// p2c_pixel_calc: one pixel of a group and its frame-store address
// Gathers bit (7 - k) of each plane into a 4-bit index and forms
// (origin_y + row) * pitch + origin_x + col, wrapped to the address width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2c_pixel_calc (
  input  wire logic [p2c_pkg::PLANES-1:0][7:0]  planes_i,
  input  wire logic [2:0]                       bit_sel_i,
  input  wire p2c_pkg::pos_t                    pos_i,
  input  wire p2c_pkg::geom_t                   geom_i,
  output logic      [p2c_pkg::PIX_W-1:0]        pixel_o,
  output logic      [p2c_pkg::ADDR_W-1:0]       addr_o
);
  import p2c_pkg::*;

  logic [2:0]                 bit_idx;
  logic [ROW_W:0]             row_abs;
  logic [ROW_W+PITCH_W:0]     row_base;
  logic [COL_W:0]             col_abs;
  logic [ROW_W+PITCH_W+1:0]   addr_full;

  // leftmost pixel sits in bit 7
  assign bit_idx = ~bit_sel_i;

  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      pixel_o[p] = planes_i[p][bit_idx];
    end
  end

  // row times pitch plus column
  assign row_abs   = {1'b0, geom_i.origin_y} + {1'b0, pos_i.row};
  assign row_base  = row_abs * geom_i.pitch;
  assign col_abs   = {1'b0, geom_i.origin_x} + {1'b0, pos_i.col};
  assign addr_full = {1'b0, row_base} + (ROW_W+PITCH_W+2)'(col_abs);
  assign addr_o    = addr_full[ADDR_W-1:0];

endmodule

`default_nettype wire

### sv/planar_to_chunky_blitter_unit.sv
// ----------------------------------------------------------------------------
// planar_to_chunky_blitter_unit: four-bitplane to 4-bit chunky converter
// Walks a rectangle in raster order, one chunky pixel per output beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat carries the four plane bytes in s_tdata and a
//   restart flag in s_tuser; the flag returns to the rectangle's top-left
//   pixel before the beat is unpacked.
//   Master stream: one beat per pixel, colour index and frame-store address
//   in m_tdata, m_tlast on the last pixel of an input beat, m_tuser on the
//   final pixel of the rectangle.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i; only
//   write while the block is idle. Unknown indexes are ignored.
// Timing:
//   An accepted input beat is held in the group register and each pixel
//   leaves through the output register; up to eight pixels per input, one
//   per cycle while m_tready allows, paced by the single output register.
//   A beat giving no pixels (rectangle finished) never waits on the output.
//   The next input beat is taken in the cycle the group emits its last pixel.
// Reset and stall:
//   Reset clears the position, the finished flag, both stream stages and
//   loads the default rectangle (640 x 480, pitch 640). When m_tready is low
//   the output beat holds and unpacking pauses; s_tready drops until the
//   group can finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module planar_to_chunky_blitter_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write port
  input  wire logic                            cfg_we_i,
  input  wire logic [p2c_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [p2c_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [31:0]                     s_tdata,  // plane0..plane3 bytes
  input  wire logic                            s_tuser,  // block_start
  // output stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [23:0]                          m_tdata,  // pixel_value, dest_address
  output logic                                 m_tlast,  // last_in_group
  output logic                                 m_tuser   // block_done
);
  import p2c_pkg::*;

  // configuration registers
  logic [COL_W-1:0]   origin_x_q;
  logic [ROW_W-1:0]   origin_y_q;
  logic [COL_W-1:0]   width_q;
  logic [ROW_W-1:0]   height_q;
  logic [PITCH_W-1:0] pitch_q;

  // rectangle walk state
  pos_t pos_q, pos_d;
  logic finished_q, finished_d;

  // group register
  logic                        grp_valid_q;
  logic [PLANES-1:0][7:0]      grp_planes_q;
  logic [2:0]                  k_q;

  // output register
  logic               out_valid_q;
  logic [PIX_W-1:0]   out_pix_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic               out_last_q;
  logic               out_done_q;

  // step signals
  logic               in_acc;
  logic               out_free;
  logic               empty_rect;
  logic               emit;
  logic               step_en;
  logic               emit_step;
  logic               grp_end;
  logic               rect_end;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   row_nxt;
  logic               row_wrap;
  logic [PIX_W-1:0]   pix;
  logic [ADDR_W-1:0]  addr;
  geom_t              geom;

  assign geom = '{origin_x: origin_x_q, origin_y: origin_y_q, pitch: pitch_q};

  p2c_pixel_calc u_calc (
    .planes_i  (grp_planes_q),
    .bit_sel_i (k_q),
    .pos_i     (pos_q),
    .geom_i    (geom),
    .pixel_o   (pix),
    .addr_o    (addr)
  );

  // decide what the group does this cycle
  assign empty_rect = (width_q == '0) || (height_q == '0) || (pos_q.row >= height_q);
  assign emit       = grp_valid_q && !finished_q && !empty_rect;
  assign out_free   = !out_valid_q || m_tready;
  assign step_en    = grp_valid_q && (!emit || out_free);
  assign emit_step  = step_en && emit;

  assign col_nxt  = pos_q.col + COL_W'(1);
  assign row_wrap = (col_nxt >= width_q) || (col_nxt == '0);
  assign row_nxt  = pos_q.row + ROW_W'(1);
  assign rect_end = row_wrap && ((row_nxt >= height_q) || (row_nxt == '0));

  assign grp_end  = step_en && (!emit || (k_q == 3'd7) || rect_end);
  assign s_tready = !grp_valid_q || grp_end;
  assign in_acc   = s_tvalid && s_tready;

  // next position; a restart beat overrides the last step of the old group
  always_comb begin
    pos_d      = pos_q;
    finished_d = finished_q;
    if (step_en && !finished_q && empty_rect) begin
      finished_d = 1'b1;
    end else if (emit_step) begin
      if (row_wrap) begin
        pos_d.col = '0;
        pos_d.row = row_nxt;
        if (rect_end) finished_d = 1'b1;
      end else begin
        pos_d.col = col_nxt;
      end
    end
    if (in_acc && s_tuser) begin
      pos_d      = '0;
      finished_d = 1'b0;
    end
  end

  // config registers and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      width_q    <= COL_W'(SCREEN_WIDTH);
      height_q   <= ROW_W'(SCREEN_HEIGHT);
      pitch_q    <= PITCH_RESET;
      pos_q      <= '0;
      finished_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ORIGIN_X:     origin_x_q <= cfg_data_i[COL_W-1:0];
          CFG_ORIGIN_Y:     origin_y_q <= cfg_data_i[ROW_W-1:0];
          CFG_BLOCK_WIDTH:  width_q    <= cfg_data_i[COL_W-1:0];
          CFG_BLOCK_HEIGHT: height_q   <= cfg_data_i[ROW_W-1:0];
          CFG_LINE_PITCH:   pitch_q    <= cfg_data_i[PITCH_W-1:0];
          default: ;
        endcase
      end
      pos_q      <= pos_d;
      finished_q <= finished_d;
    end
  end

  // group register and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (in_acc) begin
        grp_valid_q <= 1'b1;
        k_q         <= '0;
      end else if (grp_end) begin
        grp_valid_q <= 1'b0;
      end else if (emit_step) begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) grp_planes_q <= s_tdata;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_step) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_step) begin
      out_pix_q  <= pix;
      out_addr_q <= addr;
      out_last_q <= (k_q == 3'd7) || rect_end;
      out_done_q <= rect_end;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {out_addr_q, out_pix_q};
  assign m_tlast  = out_last_q;
  assign m_tuser  = out_done_q;

  // checks
  a_no_pixel_when_finished : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> !emit)
    else $error("pixel emitted after rectangle finished");

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (!m_tuser || m_tlast))
    else $error("block_done without last_in_group");

  a_group_starts_at_bit7 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (k_q == 3'd0))
    else $error("bit counter not cleared for new group");

  a_done_sets_finished : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_step && rect_end && !(in_acc && s_tuser)) |=> finished_q)
    else $error("final pixel did not mark rectangle finished");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for planar_to_chunky_blitter_unit
// Sends four-plane byte beats with random gaps and takes the pixel stream
// under random back-pressure. An in-bench model of the rectangle walk keeps
// a queue of expected pixels, and each output beat is checked against it
// field by field. Directed tests cover the special cases; a long random run
// over many small rectangles follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import p2c_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned RANDOM_GROUPS = 280;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(CFG_LINE_PITCH) + 1'b1;

  // one expected chunky pixel
  typedef struct {
    logic [PIX_W-1:0]  colour;
    logic [ADDR_W-1:0] addr;
    logic              group_end;
    logic              rect_end;
  } pixel_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // plane0, plane1, plane2, plane3 bytes
  logic                  s_tuser;   // block_start
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;   // pixel_value[3:0], dest_address[23:4]
  logic                  m_tlast;   // last_in_group
  logic                  m_tuser;   // block_done

  // register copies and walk state of the pixel model
  logic [COL_W-1:0]   org_x  = '0;
  logic [ROW_W-1:0]   org_y  = '0;
  logic [COL_W-1:0]   rect_w = COL_W'(SCREEN_WIDTH);
  logic [ROW_W-1:0]   rect_h = ROW_W'(SCREEN_HEIGHT);
  logic [PITCH_W-1:0] pitch  = PITCH_RESET;
  logic [COL_W-1:0]   col_pos = '0;
  logic [ROW_W-1:0]   row_pos = '0;
  logic               rect_finished = 1'b0;

  pixel_t      pixel_queue[$];
  int          fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned groups_sent  = 0;
  int unsigned busy_groups  = 0;
  int unsigned pixels_seen  = 0;
  int unsigned rects_done   = 0;
  bit          tx_gappy     = 1'b1;

  planar_to_chunky_blitter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still awaited", cycle_count,
               pixel_queue.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Walk the rectangle for one plane beat and queue the pixels it yields.
  function automatic int predict_pixels(input logic [31:0] planes, input logic start);
    pixel_t      px;
    int          produced;
    int unsigned full_addr;
    produced = 0;
    if (start) begin
      col_pos       = '0;
      row_pos       = '0;
      rect_finished = 1'b0;
    end
    for (int k = 0; k < 8; k++) begin
      if (rect_finished) break;
      // empty rectangle, or rows already past the height
      if (rect_w == '0 || rect_h == '0 || row_pos >= rect_h) begin
        rect_finished = 1'b1;
        break;
      end
      for (int p = 0; p < PLANES; p++) px.colour[p] = planes[8*p + 7 - k];
      full_addr = (32'(org_y) + 32'(row_pos)) * 32'(pitch) + 32'(org_x) + 32'(col_pos);
      px.addr      = full_addr[ADDR_W-1:0];
      px.group_end = (k == 7);
      px.rect_end  = 1'b0;
      // column steps on; a column at or past the width wraps to the next row
      col_pos = col_pos + 1'b1;
      if (col_pos >= rect_w || col_pos == '0) begin
        col_pos = '0;
        row_pos = row_pos + 1'b1;
        if (row_pos >= rect_h || row_pos == '0) begin
          rect_finished = 1'b1;
          px.group_end  = 1'b1;
          px.rect_end   = 1'b1;
        end
      end
      pixel_queue.push_back(px);
      produced++;
    end
    return produced;
  endfunction

  // One plane beat through the slave handshake, with a random gap first.
  task automatic send_group(input logic [31:0] planes, input logic start);
    int unsigned gap;
    gap = tx_gappy ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= planes;
    s_tuser  <= start;
    do @(posedge clk_i); while (!s_tready);
    groups_sent++;
    if (predict_pixels(planes, start) != 0) busy_groups++;
  endtask

  // Stop sending, let every expected pixel arrive, then let the block settle.
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_ORIGIN_X:     org_x  = value[COL_W-1:0];
      CFG_ORIGIN_Y:     org_y  = value[ROW_W-1:0];
      CFG_BLOCK_WIDTH:  rect_w = value[COL_W-1:0];
      CFG_BLOCK_HEIGHT: rect_h = value[ROW_W-1:0];
      CFG_LINE_PITCH:   pitch  = value[PITCH_W-1:0];
      default: ;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned ox, input int unsigned oy, input int unsigned w,
                              input int unsigned h, input int unsigned lp);
    write_reg(CFG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(CFG_BLOCK_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_BLOCK_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_LINE_PITCH, CFG_DATA_W'(lp));
  endtask

  // Default 640 x 480 rectangle straight out of reset, no restart flag.
  task automatic test_reset_geometry();
    send_group({8'h55, 8'hAA, 8'h00, 8'hFF}, 1'b0);
    send_group({8'h01, 8'h80, 8'hFF, 8'h00}, 1'b0);
    wait_for_idle();
  endtask

  // 5 x 3: groups straddle rows, the last group is cut short, then nothing
  // more comes until a restart.
  task automatic test_partial_group();
    set_geometry(3, 2, 5, 3, 16);
    send_group({8'hF0, 8'hCC, 8'hAA, 8'h0F}, 1'b1);
    send_group({8'h3C, 8'h99, 8'h55, 8'hFF}, 1'b0);
    send_group({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
    send_group({8'h12, 8'h34, 8'h56, 8'h78}, 1'b0);
    send_group({8'h81, 8'h42, 8'h24, 8'h18}, 1'b1);
    wait_for_idle();
  endtask

  // zero width, zero height, and writes to unused register indexes
  task automatic test_empty_rectangle();
    set_geometry(0, 0, 0, 4, 8);
    send_group({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
    wait_for_idle();
    write_reg(CFG_BLOCK_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_BLOCK_HEIGHT, CFG_DATA_W'(0));
    send_group({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
    wait_for_idle();
    write_reg(CFG_BLOCK_HEIGHT, CFG_DATA_W'(2));
    write_reg(FIRST_SPARE_IDX, '1);
    write_reg(FIRST_SPARE_IDX + 2'd2, '0);
    send_group({8'hA5, 8'h5A, 8'hC3, 8'h3C}, 1'b1);
    wait_for_idle();
  endtask

  // largest origins and pitch, the address wraps to 20 bits; pitch of zero
  task automatic test_address_wrap();
    set_geometry(1023, 511, 10, 2, 4095);
    send_group({8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b1);
    send_group({8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b0);
    wait_for_idle();
    set_geometry(639, 479, 640, 480, 2048);
    send_group({8'hE7, 8'h7E, 8'hDB, 8'hBD}, 1'b1);
    wait_for_idle();
    write_reg(CFG_LINE_PITCH, CFG_DATA_W'(0));
    send_group({8'h11, 8'h22, 8'h44, 8'h88}, 1'b1);
    wait_for_idle();
  endtask

  // width shrunk below the column, then height below the row, mid-rectangle
  task automatic test_geometry_change();
    set_geometry(0, 0, 16, 4, 32);
    send_group({8'h0F, 8'h33, 8'h55, 8'hFF}, 1'b1);
    wait_for_idle();
    write_reg(CFG_BLOCK_WIDTH, CFG_DATA_W'(4));
    send_group({8'hF0, 8'hCC, 8'hAA, 8'h00}, 1'b0);
    wait_for_idle();
    write_reg(CFG_BLOCK_HEIGHT, CFG_DATA_W'(1));
    send_group({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
    wait_for_idle();
  endtask

  // Mostly whole rectangles with random content; some cut short by restarts,
  // some with spare beats after the end, the odd width change part-way.
  task automatic test_random_rectangles();
    int unsigned first_busy;
    int unsigned w;
    int unsigned h;
    int unsigned groups;
    int unsigned beats;
    logic        broken;
    first_busy = busy_groups;
    while (busy_groups - first_busy < RANDOM_GROUPS) begin
      case ($urandom_range(0, 15))
        0: begin
          w = $urandom_range(64, 320);
          h = 1;
        end
        1: begin
          w = 1;
          h = $urandom_range(64, 511);
        end
        default: begin
          w = $urandom_range(1, 24);
          h = $urandom_range(1, 6);
        end
      endcase
      set_geometry($urandom_range(0, 1023), $urandom_range(0, 511), w, h,
                   $urandom_range(0, 4095));
      if ($urandom_range(0, 15) == 0) write_reg(FIRST_SPARE_IDX + 2'($urandom_range(0, 2)),
                                                CFG_DATA_W'($urandom));
      tx_gappy = ($urandom_range(0, 2) != 0);
      groups   = (w * h + 7) / 8;
      broken   = ($urandom_range(0, 7) == 0);
      beats    = (broken ? $urandom_range(1, groups) : groups) + $urandom_range(0, 2);
      for (int i = 0; i < beats; i++) begin
        if (i != 0 && $urandom_range(0, 47) == 0) begin
          wait_for_idle();
          write_reg(CFG_BLOCK_WIDTH, CFG_DATA_W'($urandom_range(1, 24)));
        end
        send_group($urandom, i == 0 || (broken && $urandom_range(0, 3) == 0));
      end
      wait_for_idle();
    end
  endtask

  // Output side: random stall per beat, each beat checked against the queue.
  initial begin : pixel_sink
    int unsigned stall;
    int unsigned beats;
    bit          rx_gappy;
    pixel_t      want;
    beats    = 0;
    rx_gappy = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (beats % 48 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
      stall = rx_gappy ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      beats++;
      pixels_seen++;
      if (m_tuser) rects_done++;
      if (pixel_queue.size() == 0) begin
        $error("pixel beat with nothing expected: colour %0d address 0x%05h",
               m_tdata[PIX_W-1:0], m_tdata[PIX_W +: ADDR_W]);
        fail_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (m_tdata[PIX_W-1:0] !== want.colour) begin
          $error("pixel_value: expected %0d, got %0d", want.colour, m_tdata[PIX_W-1:0]);
          fail_count++;
        end
        if (m_tdata[PIX_W +: ADDR_W] !== want.addr) begin
          $error("dest_address: expected 0x%05h, got 0x%05h", want.addr,
                 m_tdata[PIX_W +: ADDR_W]);
          fail_count++;
        end
        if (m_tlast !== want.group_end) begin
          $error("last_in_group: expected %0d, got %0d", want.group_end, m_tlast);
          fail_count++;
        end
        if (m_tuser !== want.rect_end) begin
          $error("block_done: expected %0d, got %0d", want.rect_end, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // reset, test sequence and verdict
  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= 1'b0;
    m_tready   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_partial_group();
    test_empty_rectangle();
    test_address_wrap();
    test_geometry_change();
    test_random_rectangles();
    wait_for_idle();

    if (pixel_queue.size() != 0) begin
      $error("%0d expected pixels never arrived", pixel_queue.size());
      fail_count++;
    end
    $display("Sent %0d plane beats (%0d yielding pixels); checked %0d pixel beats",
             groups_sent, busy_groups, pixels_seen);
    $display("Saw %0d rectangles complete, %0d mismatches", rects_done, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
sv/p2c_pkg.sv
sv/p2c_pixel_calc.sv
sv/planar_to_chunky_blitter_unit.sv
tb/testbench.sv
